/* sv/ipv6c_pkg.sv */
// Shared types and constants for the IPv6 address text compressor.
package ipv6c_pkg;

  localparam logic [7:0]  CH_COLON   = 8'h3A;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [31:0] ZERO_GROUP = 32'h3030_3030;
  localparam int unsigned MAX_CHARS  = 5;
  localparam logic [2:0]  LAST_POS   = 3'd7;

  typedef enum logic [2:0] {
    PH_NONE = 3'b001,
    PH_RUN  = 3'b010,
    PH_DONE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                cnt;
    logic                      last;
  } burst_t;

endpackage

/* sv/ipv6c_decode.sv */
// Turns one registered group into its list of output characters.
module ipv6c_decode import ipv6c_pkg::*; (
  input  logic [31:0] group_text,
  input  logic [2:0]  pos,
  input  phase_t      phase,
  output burst_t      burst
);

  logic       zero;
  logic       last;
  logic [2:0] lead;
  logic [2:0] ndig;
  logic [2:0] src;

  always_comb begin
    zero = (group_text == ZERO_GROUP);
    last = (pos == LAST_POS);
    priority if (group_text[31:24] != CH_ZERO) begin
      lead = 3'd0;
    end else if (group_text[23:16] != CH_ZERO) begin
      lead = 3'd1;
    end else if (group_text[15:8] != CH_ZERO) begin
      lead = 3'd2;
    end else begin
      lead = 3'd3;
    end
    ndig = 3'd4 - lead;
    src  = 3'd0;

    burst.last = last;
    burst.cnt  = 3'd0;
    for (int k = 0; k < MAX_CHARS; k++) begin
      burst.chars[k] = CH_COLON;
    end

    if (zero) begin
      unique case (phase)
        PH_NONE: begin
          burst.cnt = (pos == 3'd0) ? 3'd2 : 3'd1;
        end
        PH_RUN: begin
          burst.cnt = 3'd0;
        end
        default: begin
          burst.chars[0] = CH_ZERO;
          burst.cnt      = last ? 3'd1 : 3'd2;
        end
      endcase
    end else begin
      for (int k = 0; k < MAX_CHARS; k++) begin
        src = lead + 3'(k);
        if (3'(k) < ndig) begin
          burst.chars[k] = group_text[31 - 8*src[1:0] -: 8];
        end
      end
      burst.cnt = ndig + (last ? 3'd0 : 3'd1);
    end
  end

endmodule

/* sv/ipv6c_emit.sv */
// Serializes a character list onto the result channel, one item per cycle while out_stall is low.
module ipv6c_emit import ipv6c_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       burst_valid,
  input  burst_t     burst,
  output logic       burst_free,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_group_done,
  output logic       out_address_done
);

  logic [2:0] idx_r, idx_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r;
  logic       gdone_r;
  logic       adone_r;
  logic       out_load;
  logic       emit;
  logic       last_char;

  always_comb begin
    out_load   = !valid_r || !out_stall;
    emit       = burst_valid && (burst.cnt != 3'd0) && out_load;
    last_char  = (idx_r == burst.cnt - 3'd1);
    burst_free = burst_valid && ((burst.cnt == 3'd0) || (out_load && last_char));
    idx_nxt    = idx_r;
    if (emit) begin
      idx_nxt = last_char ? 3'd0 : idx_r + 3'd1;
    end
    valid_nxt = out_load ? emit : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r  <= burst.chars[idx_r];
      gdone_r <= last_char;
      adone_r <= last_char && burst.last;
    end
  end

  assign out_valid        = valid_r;
  assign out_char         = char_r;
  assign out_group_done   = gdone_r;
  assign out_address_done = adone_r;

endmodule

/* sv/ipv6_address_text_compressor_core.sv */
// IPv6 address text compressor: full-form groups in, compressed text characters out.
//
// Input channel: in_valid / in_stall carry one group of four ASCII characters per
// item on in_group_text, first character in bits 31..24. Eight items make one
// address; the ninth starts the next address.
// Result channel: out_valid / out_stall carry one character per item on out_char,
// with out_group_done on the last character of a group and out_address_done on
// the last character of group 7. Groups of the first zero run after its first emit nothing.
// An accepted group is registered, then each character is registered again on out_char.
// Throughput: one character per cycle while out_stall is low; a group holds the
// input register until it has emitted all its characters (one to five), and a
// group that emits none frees it. The serializer over the registered group sets this rate.
// Reset (rst_n low, synchronous) empties the pipeline and returns to group 0 with
// no zero run seen. While out_stall is high the result item holds, and the input
// register fills and raises in_stall until the pending characters move on.
module ipv6_address_text_compressor_core import ipv6c_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_group_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_group_done,
  output logic        out_address_done
);

  logic        q_valid_r, q_valid_nxt;
  logic [31:0] q_group_r;
  logic [2:0]  q_pos_r;
  phase_t      q_phase_r;
  logic [2:0]  pos_r, pos_nxt;
  phase_t      phase_r, phase_nxt;
  logic        accept;
  logic        in_zero;
  logic        burst_free;
  burst_t      burst;

  always_comb begin
    in_stall    = q_valid_r && !burst_free;
    accept      = in_valid && !in_stall;
    in_zero     = (in_group_text == ZERO_GROUP);
    q_valid_nxt = accept ? 1'b1 : (burst_free ? 1'b0 : q_valid_r);
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    if (accept) begin
      if (pos_r == LAST_POS) begin
        pos_nxt   = 3'd0;
        phase_nxt = PH_NONE;
      end else begin
        pos_nxt = pos_r + 3'd1;
        if (in_zero && phase_r == PH_NONE) begin
          phase_nxt = PH_RUN;
        end else if (!in_zero && phase_r == PH_RUN) begin
          phase_nxt = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
      pos_r     <= 3'd0;
      phase_r   <= PH_NONE;
    end else begin
      q_valid_r <= q_valid_nxt;
      pos_r     <= pos_nxt;
      phase_r   <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_group_r <= in_group_text;
      q_pos_r   <= pos_r;
      q_phase_r <= phase_r;
    end
  end

  ipv6c_decode u_decode (
    .group_text (q_group_r),
    .pos        (q_pos_r),
    .phase      (q_phase_r),
    .burst      (burst)
  );

  ipv6c_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .burst_valid      (q_valid_r),
    .burst            (burst),
    .burst_free       (burst_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_group_done   (out_group_done),
    .out_address_done (out_address_done)
  );

endmodule

/* tb/ipv6_address_text_compressor_core_compare.sv */
// Predicts the compressed address text from accepted groups and compares it with the output.
module ipv6_address_text_compressor_core_compare import ipv6c_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_group_text,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_char,
  input  logic        out_group_done,
  input  logic        out_address_done,
  output int          fail_count,
  output int          pending_chars
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [7:0] ch;
    logic       grp_done;
    logic       addr_done;
  } text_char_t;

  text_char_t text_queue[$];
  logic [2:0] grp_pos   = '0;
  phase_t     run_phase = PH_NONE;

  initial begin
    fail_count    = 0;
    pending_chars = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < PRINT_CAP) begin
      $display("%0t ns: %s", $realtime, what);
    end
    fail_count++;
  endtask

  // One group's worth of characters; done flags go on the last one emitted.
  function automatic void compress_group(input logic [31:0] g);
    logic [7:0] chars [5];
    int         n;
    int         lead;
    logic       last;
    text_char_t tc;
    n = 0;
    last = (grp_pos == LAST_POS);
    if (g == ZERO_GROUP) begin
      if (run_phase == PH_NONE) begin
        chars[n++] = CH_COLON;
        if (grp_pos == '0) begin
          chars[n++] = CH_COLON;
        end
        run_phase = PH_RUN;
      end else if (run_phase != PH_RUN) begin
        chars[n++] = CH_ZERO;
        if (!last) begin
          chars[n++] = CH_COLON;
        end
      end
    end else begin
      if (run_phase == PH_RUN) begin
        run_phase = PH_DONE;
      end
      lead = 0;
      while (lead < 3 && g[31-8*lead -: 8] == CH_ZERO) lead++;
      for (int i = lead; i < 4; i++) begin
        chars[n++] = g[31-8*i -: 8];
      end
      if (!last) begin
        chars[n++] = CH_COLON;
      end
    end
    for (int i = 0; i < n; i++) begin
      tc.ch        = chars[i];
      tc.grp_done  = (i == n - 1);
      tc.addr_done = (i == n - 1) && last;
      text_queue.push_back(tc);
    end
    if (last) begin
      grp_pos   = '0;
      run_phase = PH_NONE;
    end else begin
      grp_pos = grp_pos + 3'd1;
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (text_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h gd=%0b ad=%0b",
                                    out_char, out_group_done, out_address_done));
        end else begin
          want = text_queue.pop_front();
          if (out_char !== want.ch) begin
            report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h", out_char, want.ch));
          end
          if (out_group_done !== want.grp_done) begin
            report_mismatch($sformatf("out_group_done %0b, expected %0b on char 0x%02h",
                                      out_group_done, want.grp_done, want.ch));
          end
          if (out_address_done !== want.addr_done) begin
            report_mismatch($sformatf("out_address_done %0b, expected %0b on char 0x%02h",
                                      out_address_done, want.addr_done, want.ch));
          end
        end
      end
      if (in_valid && !in_stall) begin
        compress_group(in_group_text);
      end
    end
    pending_chars <= text_queue.size();
  end

endmodule

/* tb/ipv6_address_text_compressor_core_test.sv */
// Stimulus, handshake pacing, watchdog and verdict for the IPv6 address text compressor.
module ipv6_address_text_compressor_core_test import ipv6c_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ADDRESSES = 44;
  localparam int IDLE_LIMIT       = 1000;
  localparam int DRAIN_CYCLES     = 16;
  localparam int MAX_GAP          = 13;

  // all-zero address, a run in the middle, then a run at group 0 with odd bytes
  localparam logic [31:0] DIRECTED_GROUPS [24] = '{
    ZERO_GROUP, ZERO_GROUP, ZERO_GROUP, ZERO_GROUP,
    ZERO_GROUP, ZERO_GROUP, ZERO_GROUP, ZERO_GROUP,
    "FFFF", ZERO_GROUP, ZERO_GROUP, "00a0",
    ZERO_GROUP, ZERO_GROUP, "0DB8", "0001",
    ZERO_GROUP, ZERO_GROUP, 32'h3030_3000, 32'h0000_0000,
    32'hFFFF_FFFF, ZERO_GROUP, "abcd", ZERO_GROUP
  };

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [31:0] in_group_text    = '0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [7:0]  out_char;
  logic        out_group_done;
  logic        out_address_done;
  int          fail_count;
  int          pending_chars;
  logic        tx_quiet         = 1'b0;

  ipv6_address_text_compressor_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_group_text    (in_group_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_group_done   (out_group_done),
    .out_address_done (out_address_done)
  );

  ipv6_address_text_compressor_core_compare u_compare (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_group_text    (in_group_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_group_done   (out_group_done),
    .out_address_done (out_address_done),
    .fail_count       (fail_count),
    .pending_chars    (pending_chars)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [7:0] hex_char();
    logic [3:0] nib;
    nib = 4'($urandom_range(0, 15));
    if (nib < 4'd10) begin
      return 8'h30 + 8'(nib);
    end
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [31:0] draw_group();
    int          kind;
    int          lead;
    logic [31:0] g;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      return ZERO_GROUP;
    end
    if (kind == 3) begin
      return $urandom;
    end
    g = {hex_char(), hex_char(), hex_char(), hex_char()};
    lead = $urandom_range(0, 3);
    for (int i = 0; i < lead; i++) begin
      g[31-8*i -: 8] = CH_ZERO;
    end
    return g;
  endfunction

  task automatic send_group(input logic [31:0] g);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_group_text <= g;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // result side: per-char stall draw, with occasional stretches of no stall
  initial begin
    int gap;
    int taken;
    logic rx_quiet;
    taken = 0;
    rx_quiet = 1'b0;
    forever begin
      if (taken % 20 == 0) begin
        rx_quiet = ($urandom_range(0, 4) == 0);
      end
      gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
      taken++;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("ipv6_address_text_compressor_core_test NOT OK");
    $finish;
  end

  initial begin
    logic [31:0] addr [8];
    int          span_lo;
    int          span_len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_GROUPS[i]) begin
      send_group(DIRECTED_GROUPS[i]);
    end
    for (int a = 0; a < RANDOM_ADDRESSES; a++) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      foreach (addr[j]) begin
        addr[j] = draw_group();
      end
      if ($urandom_range(0, 2) == 0) begin
        span_lo  = $urandom_range(0, 7);
        span_len = $urandom_range(1, 8 - span_lo);
        for (int j = span_lo; j < span_lo + span_len; j++) begin
          addr[j] = ZERO_GROUP;
        end
      end
      foreach (addr[j]) begin
        send_group(addr[j]);
      end
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_chars != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ipv6_address_text_compressor_core_test OK");
    end else begin
      $display("ipv6_address_text_compressor_core_test NOT OK");
    end
    $finish;
  end

endmodule
